// File: rtl/sync_frame_crc8_checker_macros.svh
// ----------------------------------------------------------------------------
// sync_frame_crc8_checker assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_CRC8_CHECKER_MACROS_SVH
`define SYNC_FRAME_CRC8_CHECKER_MACROS_SVH

// property that must hold at every edge out of reset
`define SFC8_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define SFC8_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/sfc8_pkg.sv
// ----------------------------------------------------------------------------
// sfc8_pkg
// constants, event codes and the crc-8 byte step of the frame checker
// ----------------------------------------------------------------------------
package sfc8_pkg;

    localparam int SFC8_MSG_LEN  = 9;
    localparam int SFC8_CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [SFC8_CFG_IDX_W-1:0] CFG_HEADER    = 3'd0;
    localparam logic [SFC8_CFG_IDX_W-1:0] CFG_TRAILER   = 3'd1;
    localparam logic [SFC8_CFG_IDX_W-1:0] CFG_TRAIL_EN  = 3'd2;
    localparam logic [SFC8_CFG_IDX_W-1:0] CFG_MIN_VALID = 3'd3;
    localparam logic [SFC8_CFG_IDX_W-1:0] CFG_POLY      = 3'd4;
    localparam logic [SFC8_CFG_IDX_W-1:0] CFG_FINAL_XOR = 3'd5;

    // register reset values
    localparam logic [7:0] RST_HEADER    = 8'h55;
    localparam logic [7:0] RST_TRAILER   = 8'h05;
    localparam logic       RST_TRAIL_EN  = 1'b1;
    localparam logic [7:0] RST_MIN_VALID = 8'd10;
    localparam logic [7:0] RST_POLY      = 8'h31;
    localparam logic [7:0] RST_FINAL_XOR = 8'hBB;

    // sync event codes
    localparam logic [1:0] SEV_NONE   = 2'd0;
    localparam logic [1:0] SEV_LOST   = 2'd1;
    localparam logic [1:0] SEV_GAINED = 2'd2;

    // frame event codes
    localparam logic [2:0] FEV_NONE       = 3'd0;
    localparam logic [2:0] FEV_DROPPED    = 3'd1;
    localparam logic [2:0] FEV_HELD       = 3'd2;
    localparam logic [2:0] FEV_DISPATCHED = 3'd3;
    localparam logic [2:0] FEV_BADCRC     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    // one byte through an msb-first crc-8, x^8 implied
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/sync_frame_crc8_checker.sv
// ----------------------------------------------------------------------------
// sync_frame_crc8_checker
// framed byte receiver with header sync tracking and crc-8 frame check
// ----------------------------------------------------------------------------
// output: a result item is registered, shown in the cycle after its input item;
//   a replayed frame goes via the read data and output registers, one byte per
//   cycle while the output accepts. input: one item per cycle while gathering and
//   the output accepts; a passing frame closes it for its replay (one read port)
// reset: synchronous active low; control and config registers to defaults,
//   payload registers and frame memory (each entry written before read) kept
`include "sync_frame_crc8_checker_macros.svh"

module sync_frame_crc8_checker #(
    parameter int MSG_LEN = sfc8_pkg::SFC8_MSG_LEN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [sfc8_pkg::SFC8_CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [7:0]                        i_cfg_wdata,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
    input  logic                              s_axis_tuser,  // [0] action
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // [7:0] frame_byte,
                                                             // [15:8] computed_crc
    output logic [5:0]                        m_axis_tuser,  // [1:0] sync_event,
                                                             // [4:2] frame_event,
                                                             // [5] byte_valid
    output logic                              m_axis_tlast
);
    import sfc8_pkg::*;

    localparam int AW       = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
    localparam int CW       = $clog2(MSG_LEN + 1);
    localparam int LAST_IDX = MSG_LEN - 1;

    // configuration registers
    logic [7:0] r_header, r_trailer, r_min_valid, r_poly, r_final_xor;
    logic       r_trail_en;

    // frame memory, one read port with registered data
    logic [7:0] r_mem [MSG_LEN];
    logic [7:0] r_rdata;

    // control state
    t_state      r_state, n_state;
    logic [AW-1:0] r_byte_idx, n_byte_idx;
    logic [8:0]  r_valid_frames, n_valid_frames;
    logic [7:0]  r_crc, n_crc;            // running crc over the frame so far
    logic [7:0]  r_crc_hold, n_crc_hold;  // final crc of the frame in replay
    logic [1:0]  r_sev_hold, n_sev_hold;  // sync event for the first replayed byte
    logic [CW-1:0] r_rd_addr, n_rd_addr;  // next memory read to issue
    logic [CW-1:0] r_out_cnt, n_out_cnt;  // bytes already handed to output
    logic        r_rdv, n_rdv;            // r_rdata holds an unsent byte

    // output register
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_osev, n_osev;
    logic [2:0]  r_ofev, n_ofev;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_obval, n_obval;
    logic [7:0]  r_ocrc, n_ocrc;
    logic        r_olast, n_olast;

    logic        out_free, in_acc, rd_en, mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]  rx, frame_crc;
    logic        act;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;
    assign act           = s_axis_tuser;
    assign frame_crc     = r_crc ^ r_final_xor;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ocrc, r_obyte};
    assign m_axis_tuser  = {r_obval, r_ofev, r_osev};
    assign m_axis_tlast  = r_olast;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= RST_HEADER;
            r_trailer   <= RST_TRAILER;
            r_trail_en  <= RST_TRAIL_EN;
            r_min_valid <= RST_MIN_VALID;
            r_poly      <= RST_POLY;
            r_final_xor <= RST_FINAL_XOR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HEADER:    r_header    <= i_cfg_wdata;
                CFG_TRAILER:   r_trailer   <= i_cfg_wdata;
                CFG_TRAIL_EN:  r_trail_en  <= i_cfg_wdata[0];
                CFG_MIN_VALID: r_min_valid <= i_cfg_wdata;
                CFG_POLY:      r_poly      <= i_cfg_wdata;
                CFG_FINAL_XOR: r_final_xor <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state        = r_state;
        n_byte_idx     = r_byte_idx;
        n_valid_frames = r_valid_frames;
        n_crc          = r_crc;
        n_crc_hold     = r_crc_hold;
        n_sev_hold     = r_sev_hold;
        n_rd_addr      = r_rd_addr;
        n_out_cnt      = r_out_cnt;
        n_rdv          = r_rdv;
        n_ovalid       = r_ovalid && !m_axis_tready;
        n_osev         = r_osev;
        n_ofev         = r_ofev;
        n_obyte        = r_obyte;
        n_obval        = r_obval;
        n_ocrc         = r_ocrc;
        n_olast        = r_olast;
        mem_we         = 1'b0;
        mem_waddr      = r_byte_idx;
        rd_en          = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (act) begin
                        // wire idle: restart frame and sync count
                        n_byte_idx     = '0;
                        n_valid_frames = '0;
                        n_ovalid = 1'b1;
                        n_osev   = SEV_LOST;
                        n_ofev   = FEV_NONE;
                        n_obyte  = '0;
                        n_obval  = 1'b0;
                        n_ocrc   = '0;
                        n_olast  = 1'b1;
                    end else if (r_byte_idx == '0) begin
                        if (rx == r_header) begin
                            mem_we     = 1'b1;
                            n_byte_idx = AW'(1);
                            n_crc      = crc8_step(8'h00, rx, r_poly);
                        end else if (r_trail_en && rx == r_trailer) begin
                            // trailer between frames, consumed silently
                        end else begin
                            n_valid_frames = '0;
                            n_ovalid = 1'b1;
                            n_osev   = SEV_LOST;
                            n_ofev   = FEV_DROPPED;
                            n_obyte  = '0;
                            n_obval  = 1'b0;
                            n_ocrc   = '0;
                            n_olast  = 1'b1;
                        end
                    end else if (r_byte_idx == AW'(LAST_IDX)) begin
                        // frame complete; the crc byte is rx itself
                        mem_we     = 1'b1;
                        n_byte_idx = '0;
                        if (r_valid_frames < {1'b0, r_min_valid}) begin
                            n_valid_frames = r_valid_frames + 9'd1;
                            n_ovalid = 1'b1;
                            n_osev   = SEV_NONE;
                            n_ofev   = FEV_HELD;
                            n_obyte  = '0;
                            n_obval  = 1'b0;
                            n_ocrc   = '0;
                            n_olast  = 1'b1;
                        end else begin
                            n_sev_hold = SEV_NONE;
                            if (r_valid_frames == {1'b0, r_min_valid}) begin
                                n_valid_frames = r_valid_frames + 9'd1;
                                n_sev_hold     = SEV_GAINED;
                            end
                            if (frame_crc != rx) begin
                                n_ovalid = 1'b1;
                                n_osev   = n_sev_hold;
                                n_ofev   = FEV_BADCRC;
                                n_obyte  = '0;
                                n_obval  = 1'b0;
                                n_ocrc   = frame_crc;
                                n_olast  = 1'b1;
                            end else begin
                                // replay the frame from memory
                                n_crc_hold = frame_crc;
                                n_rd_addr  = '0;
                                n_out_cnt  = '0;
                                n_rdv      = 1'b0;
                                n_state    = ST_EMIT;
                            end
                        end
                    end else begin
                        mem_we     = 1'b1;
                        n_byte_idx = r_byte_idx + AW'(1);
                        n_crc      = crc8_step(r_crc, rx, r_poly);
                    end
                end
            end
            ST_EMIT: begin
                // issue a read when its data slot is free by the next edge
                rd_en = (r_rd_addr < CW'(MSG_LEN)) && (!r_rdv || out_free);
                if (rd_en) begin
                    n_rd_addr = r_rd_addr + CW'(1);
                end
                if (r_rdv && out_free) begin
                    n_ovalid  = 1'b1;
                    n_osev    = (r_out_cnt == '0) ? r_sev_hold : SEV_NONE;
                    n_ofev    = FEV_DISPATCHED;
                    n_obyte   = r_rdata;
                    n_obval   = 1'b1;
                    n_ocrc    = r_crc_hold;
                    n_olast   = (r_out_cnt == CW'(LAST_IDX));
                    n_out_cnt = r_out_cnt + CW'(1);
                    if (r_out_cnt == CW'(LAST_IDX)) begin
                        n_state = ST_IDLE;
                    end
                end
                n_rdv = rd_en || (r_rdv && !out_free);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // frame memory: writes only while gathering, reads only while replaying
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= rx;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_byte_idx     <= '0;
            r_valid_frames <= '0;
            r_rd_addr      <= '0;
            r_out_cnt      <= '0;
            r_rdv          <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_byte_idx     <= n_byte_idx;
            r_valid_frames <= n_valid_frames;
            r_rd_addr      <= n_rd_addr;
            r_out_cnt      <= n_out_cnt;
            r_rdv          <= n_rdv;
            r_ovalid       <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_crc      <= n_crc;
        r_crc_hold <= n_crc_hold;
        r_sev_hold <= n_sev_hold;
        r_osev     <= n_osev;
        r_ofev     <= n_ofev;
        r_obyte    <= n_obyte;
        r_obval    <= n_obval;
        r_ocrc     <= n_ocrc;
        r_olast    <= n_olast;
    end

    // input is closed for the whole replay
    `SFC8_ASSERT_IMPLIES(a_no_accept_in_emit, r_state == ST_EMIT, !s_axis_tready, "input open during replay")
    // reads run at most one byte ahead of the output
    `SFC8_ASSERT_IMPLIES(a_read_ahead, r_state == ST_EMIT, r_rd_addr == r_out_cnt + CW'(r_rdv), "replay read counter out of step")
    // only dispatched items carry a frame byte
    `SFC8_ASSERT_IMPLIES(a_bval_dispatch, r_ovalid && r_obval, r_ofev == FEV_DISPATCHED, "frame byte on a non-dispatch item")
    // the gather index never reaches the frame length
    `SFC8_ASSERT_ALWAYS(a_idx_range, r_byte_idx <= AW'(LAST_IDX), "frame index out of range")

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// streams bytes and wire-idle items through the framed crc-8 sync checker,
// predicts every result item from a cycle-free model of header sync, frame
// holding and the crc check, and compares each result item field by field
// while both stream sides stall at random outside one steady phase
// ----------------------------------------------------------------------------
module tb_top;
    import sfc8_pkg::*;

    localparam int MSG_LEN      = SFC8_MSG_LEN;
    // drain time covers the replay of a passing frame, which closes the input, plus margin
    localparam int DRAIN_CYCLES = MSG_LEN + 12;
    localparam int CYCLE_LIMIT  = 200000;
    // input item target for the whole run, directed ones included
    localparam int RANDOM_ITEMS = 470;
    localparam int IDLE_PCT     = 18;

    typedef logic [7:0] frame_t [MSG_LEN];

    // one result item, field by field
    typedef struct packed {
        logic [1:0] sync_ev;
        logic [2:0] frame_ev;
        logic [7:0] frame_byte;
        logic       byte_valid;
        logic [7:0] crc;
        logic       is_last;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // sync and crc predictor with its queue of result items still owed
    // ------------------------------------------------------------------------
    class frame_sync_tracker;
        logic [7:0]    header_byte;
        logic [7:0]    trailer_byte;
        logic          trailer_en;
        logic [7:0]    min_valid;
        logic [7:0]    poly;
        logic [7:0]    final_xor;
        frame_t        frame_buf;
        int unsigned   byte_index;
        logic [8:0]    valid_frames;
        frame_result_t owed_results[$];
        int unsigned   errors;

        function new();
            header_byte  = RST_HEADER;
            trailer_byte = RST_TRAILER;
            trailer_en   = RST_TRAIL_EN;
            min_valid    = RST_MIN_VALID;
            poly         = RST_POLY;
            final_xor    = RST_FINAL_XOR;
            byte_index   = 0;
            valid_frames = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [SFC8_CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_HEADER:    header_byte  = val;
                CFG_TRAILER:   trailer_byte = val;
                CFG_TRAIL_EN:  trailer_en   = val[0];
                CFG_MIN_VALID: min_valid    = val;
                CFG_POLY:      poly         = val;
                CFG_FINAL_XOR: final_xor    = val;
                default: ;
            endcase
        endfunction

        // msb-first crc over all bytes but the last, then the final xor
        function logic [7:0] frame_crc(frame_t f);
            logic [7:0] acc;
            acc = 8'h00;
            for (int i = 0; i < MSG_LEN - 1; i++) begin
                acc = acc ^ f[i];
                for (int k = 0; k < 8; k++) begin
                    acc = acc[7] ? ({acc[6:0], 1'b0} ^ poly) : {acc[6:0], 1'b0};
                end
            end
            return acc ^ final_xor;
        endfunction

        function void owe(logic [1:0] sev, logic [2:0] fev, logic [7:0] fb,
                          logic bv, logic [7:0] crc, logic lst);
            frame_result_t r;
            r.sync_ev    = sev;
            r.frame_ev   = fev;
            r.frame_byte = fb;
            r.byte_valid = bv;
            r.crc        = crc;
            r.is_last    = lst;
            owed_results.push_back(r);
        endfunction

        function void accept_rx_item(logic act, logic [7:0] rx);
            logic [1:0] sev;
            logic [7:0] crc;
            sev = SEV_NONE;
            if (act) begin
                byte_index   = 0;
                valid_frames = '0;
                owe(SEV_LOST, FEV_NONE, 8'h00, 1'b0, 8'h00, 1'b1);
                return;
            end
            if (byte_index == 0) begin
                // header wins over an equal trailer value
                if (rx == header_byte) begin
                    frame_buf[0] = rx;
                    byte_index   = 1;
                end else if (trailer_en && rx == trailer_byte) begin
                    return;
                end else begin
                    valid_frames = '0;
                    owe(SEV_LOST, FEV_DROPPED, 8'h00, 1'b0, 8'h00, 1'b1);
                    return;
                end
            end else begin
                frame_buf[byte_index] = rx;
                byte_index++;
            end
            if (byte_index < MSG_LEN)
                return;
            byte_index = 0;
            if (valid_frames < min_valid) begin
                valid_frames++;
                owe(SEV_NONE, FEV_HELD, 8'h00, 1'b0, 8'h00, 1'b1);
                return;
            end
            if (valid_frames == min_valid) begin
                valid_frames++;
                sev = SEV_GAINED;
            end
            crc = frame_crc(frame_buf);
            if (crc != frame_buf[MSG_LEN-1]) begin
                owe(sev, FEV_BADCRC, 8'h00, 1'b0, crc, 1'b1);
                return;
            end
            for (int i = 0; i < MSG_LEN; i++) begin
                owe((i == 0) ? sev : SEV_NONE, FEV_DISPATCHED, frame_buf[i], 1'b1, crc,
                    i == MSG_LEN - 1);
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %h", $time, got);
                return;
            end
            want = owed_results.pop_front();
            check_field("sync_event", want.sync_ev, got.sync_ev);
            check_field("frame_event", want.frame_ev, got.frame_ev);
            check_field("frame_byte", want.frame_byte, got.frame_byte);
            check_field("byte_valid", want.byte_valid, got.byte_valid);
            check_field("computed_crc", want.crc, got.crc);
            check_field("last", want.is_last, got.is_last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [SFC8_CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [7:0]                i_cfg_wdata   = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;  // [7:0] rx_byte
    logic                      s_axis_tuser  = 1'b0; // [0] action
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [15:0]               m_axis_tdata;  // [7:0] frame_byte, [15:8] computed_crc
    logic [5:0]                m_axis_tuser;  // [1:0] sync_event, [4:2] frame_event,
                                              // [5] byte_valid
    logic                      m_axis_tlast;

    frame_sync_tracker tracker;
    bit                steady = 1'b0;   // no idling on either side while set
    int unsigned       cycle_count = 0;
    int                items_sent = 0;  // input items accepted so far

    sync_frame_crc8_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random back-pressure, check at the rising edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_result({m_axis_tuser[1:0], m_axis_tuser[4:2], m_axis_tdata[7:0],
                                  m_axis_tuser[5], m_axis_tdata[15:8], m_axis_tlast});
        end
    end

    // ------------------------------------------------------------------------
    // input side drivers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------------
    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic send_item(logic act, logic [7:0] rx);
        while (take_gap()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.accept_rx_item(act, rx);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(frame_t f);
        for (int i = 0; i < MSG_LEN; i++) send_item(1'b0, f[i]);
    endtask

    // drop valid, let every owed item arrive, then give a trailing frame time
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write enable stays high across the burst, so it is lowered only once
    task automatic write_one(logic [SFC8_CFG_IDX_W-1:0] idx, logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [7:0] hdr, logic [7:0] trl, logic trl_en,
                                logic [7:0] mv, logic [7:0] pl, logic [7:0] fx);
        write_one(CFG_HEADER, hdr);
        write_one(CFG_TRAILER, trl);
        write_one(CFG_TRAIL_EN, {7'd0, trl_en});
        write_one(CFG_MIN_VALID, mv);
        write_one(CFG_POLY, pl);
        write_one(CFG_FINAL_XOR, fx);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly short hold-off so most phases reach the crc check
    function automatic logic [7:0] pick_min_valid();
        case ($urandom_range(7))
            0, 1:    return 8'd0;
            2, 3:    return 8'd1;
            4:       return 8'd2;
            5:       return 8'd3;
            6:       return RST_MIN_VALID;
            default: return 8'hFF;
        endcase
    endfunction

    // mostly aligned frames with random payload; the rest is idles, stray
    // bytes at frame start and frames cut short by an idle
    task automatic run_random_phase(int n);
        frame_t     f;
        int         made;
        int         r;
        int         cut;
        logic [7:0] junk;
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 70) begin
                if (tracker.trailer_en && tracker.trailer_byte != tracker.header_byte &&
                    $urandom_range(3) == 0)
                    send_item(1'b0, tracker.trailer_byte);
                f[0] = tracker.header_byte;
                for (int i = 1; i < MSG_LEN - 1; i++) f[i] = 8'($urandom_range(255));
                // about one frame in five carries a corrupt check byte
                f[MSG_LEN-1] = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                        : tracker.frame_crc(f);
                send_frame(f);
                made += MSG_LEN;
            end else if (r < 80) begin
                send_item(1'b1, 8'($urandom_range(255)));
                made++;
            end else if (r < 90) begin
                // trailer value, enabled or not, or any byte that is not a header
                if ($urandom_range(1) && tracker.trailer_byte != tracker.header_byte) begin
                    junk = tracker.trailer_byte;
                end else begin
                    junk = 8'($urandom_range(255));
                    if (junk == tracker.header_byte) junk = junk ^ 8'h80;
                end
                send_item(1'b0, junk);
                made++;
            end else begin
                cut = $urandom_range(MSG_LEN - 2);
                send_item(1'b0, tracker.header_byte);
                repeat (cut) send_item(1'b0, 8'($urandom_range(255)));
                send_item(1'b1, 8'($urandom_range(255)));
                made += cut + 2;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        frame_t f;
        int     phase;
        int     n;
        tracker = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: no hold-off, so the first good frame gains sync
        program_regs(RST_HEADER, RST_TRAILER, RST_TRAIL_EN, 8'd0, RST_POLY, RST_FINAL_XOR);
        send_item(1'b1, 8'hFF);          // wire idle
        send_item(1'b0, 8'h00);          // stray byte at frame start
        send_item(1'b0, RST_TRAILER);    // trailer consumed silently
        f[0] = RST_HEADER;
        f[1] = 8'h00;
        f[2] = 8'hFF;
        for (int i = 3; i < MSG_LEN - 1; i++) f[i] = 8'(8'h13 * i);
        f[MSG_LEN-1] = tracker.frame_crc(f);
        send_frame(f);                   // sync gained, dispatched
        wait_idle();

        // header equal to trailer: the header meaning wins; bad check byte,
        // and min_valid now below the frame count so no sync event
        program_regs(8'hAA, 8'hAA, 1'b1, 8'd0, 8'h07, 8'h00);
        f[0] = 8'hAA;
        for (int i = 1; i < MSG_LEN - 1; i++) f[i] = 8'(8'h2B * i);
        f[MSG_LEN-1] = tracker.frame_crc(f) ^ 8'h01;
        send_frame(f);

        // random phases; the first few pin the register extremes
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            case (phase)
                0: program_regs(8'hFF, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF);
                1: program_regs(8'h00, 8'hFF, 1'b1, 8'h00, 8'hFF, 8'h00);
                2: program_regs(RST_HEADER, RST_TRAILER, RST_TRAIL_EN, RST_MIN_VALID,
                                RST_POLY, RST_FINAL_XOR);
                3: program_regs(pick_byte(), pick_byte(), 1'b1, 8'd1, 8'h00, 8'hFF);
                default: program_regs(pick_byte(), pick_byte(), 1'($urandom_range(1)),
                                      pick_min_valid(), pick_byte(), pick_byte());
            endcase
            // one whole phase runs without any idling
            steady = (phase == 3);
            n = $urandom_range(40, 70);
            if (n > RANDOM_ITEMS - items_sent) n = RANDOM_ITEMS - items_sent;
            run_random_phase(n);
            phase++;
        end
        steady = 1'b0;
        wait_idle();

        if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/sfc8_pkg.sv
rtl/sync_frame_crc8_checker.sv
bench/tb_top.sv
